/* sv/rotation_schedule_generator_assert.svh */
// assertion macros for the rotation schedule generator
`ifndef ROTATION_SCHEDULE_GENERATOR_ASSERT_SVH
`define ROTATION_SCHEDULE_GENERATOR_ASSERT_SVH

// property checked on every clock edge, off while in reset
`define RSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on every clock edge, off while in reset
`define RSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/rsg_pkg.sv */
// types and constants shared by the rotation schedule generator
package rsg_pkg;

  localparam int MASK_W  = 16;
  localparam int CNT_W   = 5;
  localparam int BOND_W  = 4;
  localparam int TOT_W   = 10;
  localparam int ATOM_W  = 5;
  localparam int NRB_W   = 5;
  localparam int ENTRY_W = 7;

  typedef struct packed {
    logic [MASK_W-1:0] rotbond_mask;
    logic              last_atom;
  } in_word_t;

  typedef struct packed {
    logic [ATOM_W-1:0] atom_id;
    logic [BOND_W-1:0] bond_index;
    logic              is_general;
    logic              is_first;
    logic [TOT_W-1:0]  total_required;
    logic              overflow;
    logic              last_entry;
  } out_word_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BUILD,
    BK_RUN
  } back_state_e;

  // number of set bits in a mask
  function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int b = 0; b < MASK_W; b++) begin
      c = c + CNT_W'(m[b]);
    end
    return c;
  endfunction

  // position of the lowest set bit, zero for an empty mask
  function automatic logic [BOND_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
    logic [BOND_W-1:0] p;
    p = '0;
    for (int b = MASK_W - 1; b >= 0; b--) begin
      if (m[b]) begin
        p = BOND_W'(b);
      end
    end
    return p;
  endfunction

endpackage

/* sv/rsg_front.sv */
// load side: counts atoms, stores their masks and hands finished loads on
module rsg_front #(
  parameter int MAX_ATOMS = 32,
  parameter int AW        = 5,
  parameter int NW        = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  rsg_pkg::in_word_t        word_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [rsg_pkg::MASK_W-1:0] rd_data_o,
  output logic                     push_o,
  output logic [NW-1:0]            push_n_o
);

  logic [rsg_pkg::MASK_W-1:0] mem [MAX_ATOMS];
  logic [NW-1:0]              loaded_q, loaded_d;
  logic                       room;

  // count of atoms after this word, extra atoms dropped
  always_comb begin
    room     = loaded_q < NW'(MAX_ATOMS);
    loaded_d = room ? loaded_q + NW'(1) : loaded_q;
  end

  assign push_o   = accept_i && word_i.last_atom;
  assign push_n_o = loaded_d;

  // load counter, back to zero once a load ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (accept_i) begin
      loaded_q <= word_i.last_atom ? '0 : loaded_d;
    end
  end

  // mask store, registered read
  always_ff @(posedge clk_i) begin
    if (accept_i && room) begin
      mem[loaded_q[AW-1:0]] <= word_i.rotbond_mask;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

/* sv/rsg_job_fifo.sv */
// two-entry queue of atom counts between load and generation
module rsg_job_fifo #(
  parameter int W = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic         empty_o,
  output logic         full_o
);

  logic [W-1:0] buf_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign empty_o    = cnt_q == 2'd0;
  assign full_o     = cnt_q == 2'd2;
  assign pop_data_o = buf_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= ~wr_q;
      end
      if (pop_i && !empty_o) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* sv/rsg_back.sv */
// generation side: builds the sorted atom list and emits one entry per cycle
module rsg_back #(
  parameter int MAX_ATOMS     = 32,
  parameter int MAX_BONDS     = 16,
  parameter int MAX_ROTATIONS = 64,
  parameter int AW            = 5,
  parameter int NW            = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  logic [NW-1:0]                job_n_i,
  output logic                         pop_o,
  output logic [AW-1:0]                rd_addr_o,
  input  logic [rsg_pkg::MASK_W-1:0]   rd_data_i,
  input  logic [rsg_pkg::NRB_W-1:0]    num_rotbonds_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output rsg_pkg::out_word_t           res_o
);

  localparam int MA   = MAX_ATOMS;
  localparam int BCAP = (MAX_BONDS < rsg_pkg::MASK_W) ? MAX_BONDS : rsg_pkg::MASK_W;
  localparam int NXT  = 1 % MAX_ATOMS;

  rsg_pkg::back_state_e state_q, state_d;

  logic [NW-1:0]                  n_q, n_d, j_q, j_d;
  logic                           rd_vld_q, rd_vld_d;
  logic [AW-1:0]                  rd_id_q, rd_id_d;
  logic [rsg_pkg::TOT_W-1:0]      total_q, total_d;
  logic [rsg_pkg::ENTRY_W-1:0]    k_q, k_d;
  logic                           res_valid_d;
  rsg_pkg::out_word_t             res_d;

  // sorted list rows
  logic [rsg_pkg::CNT_W-1:0]  cnt_q  [MA];
  logic [rsg_pkg::CNT_W-1:0]  cnt_d  [MA];
  logic [AW-1:0]              id_q   [MA];
  logic [AW-1:0]              id_d   [MA];
  logic [rsg_pkg::MASK_W-1:0] mask_q [MA];
  logic [rsg_pkg::MASK_W-1:0] mask_d [MA];
  logic                       first_q[MA];
  logic                       first_d[MA];

  logic [rsg_pkg::NRB_W-1:0]  nb;
  logic [rsg_pkg::MASK_W-1:0] lim, ins_mask, hd_mask;
  logic [rsg_pkg::CNT_W-1:0]  ins_cnt, hd_cnt;
  logic [rsg_pkg::BOND_W-1:0] hd_bond;
  logic                       hd_gen, sched_end, lim_hit, fin;
  logic [AW+4:0]              id_ext;

  // bond limit and masked count of the word being inserted
  always_comb begin
    nb = (num_rotbonds_i > rsg_pkg::NRB_W'(BCAP)) ? rsg_pkg::NRB_W'(BCAP) : num_rotbonds_i;
    for (int b = 0; b < rsg_pkg::MASK_W; b++) begin
      lim[b] = rsg_pkg::NRB_W'(b) < nb;
    end
    ins_mask = rd_data_i & lim;
    ins_cnt  = rsg_pkg::CNT_W'(1) + rsg_pkg::popcount(ins_mask);
  end

  // head entry decode
  always_comb begin
    hd_gen    = cnt_q[0] == rsg_pkg::CNT_W'(1);
    hd_bond   = rsg_pkg::lowest_bit(mask_q[0]);
    hd_mask   = hd_gen ? mask_q[0] : (mask_q[0] & ~(rsg_pkg::MASK_W'(1) << hd_bond));
    hd_cnt    = cnt_q[0] - rsg_pkg::CNT_W'(1);
    sched_end = (hd_cnt == '0) && ((MA == 1) || (cnt_q[NXT] == '0));
    lim_hit   = k_q == rsg_pkg::ENTRY_W'(MAX_ROTATIONS - 1);
    fin       = sched_end || lim_hit;
    id_ext    = (AW + 5)'(id_q[0]);
  end

  // sequencer and list update
  always_comb begin
    int ip;
    logic gi, gn, ci, cp;
    state_d     = state_q;
    n_d         = n_q;
    j_d         = j_q;
    rd_vld_d    = 1'b0;
    rd_id_d     = rd_id_q;
    total_d     = total_q;
    k_d         = k_q;
    pop_o       = 1'b0;
    rd_addr_o   = j_q[AW-1:0];
    res_valid_d = 1'b0;
    res_d       = res_o;
    ip          = 0;
    gi          = 1'b0;
    gn          = 1'b0;
    ci          = 1'b0;
    cp          = 1'b0;
    for (int i = 0; i < MA; i++) begin
      cnt_d[i]   = cnt_q[i];
      id_d[i]    = id_q[i];
      mask_d[i]  = mask_q[i];
      first_d[i] = first_q[i];
    end

    unique case (state_q)
      rsg_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          n_d     = job_n_i;
          j_d     = '0;
          total_d = '0;
          k_d     = '0;
          state_d = rsg_pkg::BK_BUILD;
          for (int i = 0; i < MA; i++) begin
            cnt_d[i] = '0;
          end
        end
      end

      rsg_pkg::BK_BUILD: begin
        // read the next mask
        if (j_q < n_q) begin
          rd_vld_d = 1'b1;
          rd_id_d  = j_q[AW-1:0];
          j_d      = j_q + NW'(1);
        end
        // stable insertion behind every row with an equal or larger count
        if (rd_vld_q) begin
          total_d = total_q + rsg_pkg::TOT_W'(ins_cnt);
          for (int i = 0; i < MA; i++) begin
            ip = (i > 0) ? i - 1 : 0;
            ci = cnt_q[i] >= ins_cnt;
            cp = (i == 0) || (cnt_q[ip] >= ins_cnt);
            if (!ci) begin
              if (cp) begin
                cnt_d[i]   = ins_cnt;
                id_d[i]    = rd_id_q;
                mask_d[i]  = ins_mask;
                first_d[i] = 1'b1;
              end else begin
                cnt_d[i]   = cnt_q[ip];
                id_d[i]    = id_q[ip];
                mask_d[i]  = mask_q[ip];
                first_d[i] = first_q[ip];
              end
            end
          end
          if (NW'(rd_id_q) == n_q - NW'(1)) begin
            state_d = rsg_pkg::BK_RUN;
          end
        end
      end

      rsg_pkg::BK_RUN: begin
        // emit the head entry
        res_valid_d          = 1'b1;
        res_d.atom_id        = id_ext[4:0];
        res_d.bond_index     = hd_gen ? '0 : hd_bond;
        res_d.is_general     = hd_gen;
        res_d.is_first       = first_q[0];
        res_d.total_required = fin ? total_q : '0;
        res_d.overflow       = fin && !sched_end;
        res_d.last_entry     = fin;
        k_d                  = k_q + rsg_pkg::ENTRY_W'(1);
        // move the head back past every row with a larger count
        for (int i = 0; i < MA; i++) begin
          ip = (i + 1 < MA) ? i + 1 : i;
          gn = (i + 1 < MA) && (cnt_q[ip] > hd_cnt);
          gi = (i == 0) || (cnt_q[i] > hd_cnt);
          if (gn) begin
            cnt_d[i]   = cnt_q[ip];
            id_d[i]    = id_q[ip];
            mask_d[i]  = mask_q[ip];
            first_d[i] = first_q[ip];
          end else if (gi) begin
            cnt_d[i]   = hd_cnt;
            id_d[i]    = id_q[0];
            mask_d[i]  = hd_mask;
            first_d[i] = 1'b0;
          end
        end
        if (fin) begin
          state_d = rsg_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = rsg_pkg::BK_IDLE;
      end
    endcase
  end

  assign busy_o = state_q != rsg_pkg::BK_IDLE;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsg_pkg::BK_IDLE;
      rd_vld_q    <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_o <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    j_q     <= j_d;
    rd_id_q <= rd_id_d;
    total_q <= total_d;
    k_q     <= k_d;
    res_o   <= res_d;
    for (int i = 0; i < MA; i++) begin
      cnt_q[i]   <= cnt_d[i];
      id_q[i]    <= id_d[i];
      mask_q[i]  <= mask_d[i];
      first_q[i] <= first_d[i];
    end
  end

endmodule

/* sv/rotation_schedule_generator.sv */
// top level of the rotation schedule generator
//
// Atom masks are taken one per cycle while busy_o is low; the word marked
// last_atom ends the load. From the cycle after it, busy_o stays high while
// the generation unit reads the n stored masks back and inserts them into its
// sorted list (one atom per cycle through the mask memory read port), then
// emits one schedule entry per cycle on res_valid_o / res_o until the entry
// marked last_entry. busy_o falls in the cycle that shows that entry.
// Results cannot be held off: take each one on its strobe.
module rotation_schedule_generator #(
  parameter int MAX_ATOMS     = 32,
  parameter int MAX_BONDS     = 16,
  parameter int MAX_ROTATIONS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  rsg_pkg::in_word_t         in_i,
  input  logic                      cfg_we_i,
  input  logic [rsg_pkg::NRB_W-1:0] cfg_wdata_i,
  output logic                      res_valid_o,
  output rsg_pkg::out_word_t        res_o
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int NW = $clog2(MAX_ATOMS + 1);

  logic [rsg_pkg::NRB_W-1:0]  num_rotbonds_q;
  logic                       accept, push, pop, q_empty, q_full, back_busy;
  logic [NW-1:0]              push_n, job_n;
  logic [AW-1:0]              rd_addr;
  logic [rsg_pkg::MASK_W-1:0] rd_data;

  assign accept = start_i && !busy_o;
  assign busy_o = back_busy || !q_empty;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rotbonds_q <= '0;
    end else if (cfg_we_i) begin
      num_rotbonds_q <= cfg_wdata_i;
    end
  end

  rsg_front #(
    .MAX_ATOMS(MAX_ATOMS),
    .AW       (AW),
    .NW       (NW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .push_o   (push),
    .push_n_o (push_n)
  );

  rsg_job_fifo #(
    .W(NW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_n),
    .pop_i      (pop),
    .pop_data_o (job_n),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  rsg_back #(
    .MAX_ATOMS    (MAX_ATOMS),
    .MAX_BONDS    (MAX_BONDS),
    .MAX_ROTATIONS(MAX_ROTATIONS),
    .AW           (AW),
    .NW           (NW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!q_empty),
    .job_n_i       (job_n),
    .pop_o         (pop),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .num_rotbonds_i(num_rotbonds_q),
    .busy_o        (back_busy),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

endmodule

/* sv/rsg_checker.sv */
// port-level checks for the rotation schedule generator and their binding
`include "rotation_schedule_generator_assert.svh"

module rsg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input rsg_pkg::in_word_t  in_i,
  input logic               res_valid_o,
  input rsg_pkg::out_word_t res_o
);

  // an entry only follows a busy cycle
  `RSG_ASSERT_IMP(a_res_after_busy, res_valid_o, $past(busy_o), "entry without busy")
  // an accepted last atom raises busy_o
  `RSG_ASSERT(a_last_busy, start_i && !busy_o && in_i.last_atom |=> busy_o, "no busy after last atom")
  // general rotations carry no bond
  `RSG_ASSERT_IMP(a_gen_bond, res_valid_o && res_o.is_general, res_o.bond_index == '0, "bond on general")
  // overflow and total only on the final word
  `RSG_ASSERT_IMP(a_ovf_last, res_valid_o && res_o.overflow, res_o.last_entry, "overflow not last")
  `RSG_ASSERT_IMP(a_total_last, res_valid_o && !res_o.last_entry, res_o.total_required == '0, "early total")

endmodule

bind rotation_schedule_generator rsg_checker u_rsg_checker (.*);

/* bench/tb_rotation_schedule_generator.sv */
// testbench for the rotation schedule generator: directed table plus random ligands
`timescale 1ns / 100ps

module tb_rotation_schedule_generator;

  localparam int N_ATOMS = 32;
  localparam int N_ROT   = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  // single general rotation of atom zero closing a one-entry schedule
  localparam rsg_pkg::out_word_t GEN_ONLY = '{
    atom_id: '0, bond_index: '0, is_general: 1'b1, is_first: 1'b1,
    total_required: 10'd1, overflow: 1'b0, last_entry: 1'b1
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  rsg_pkg::in_word_t         in_i;
  logic                      cfg_we_i;
  logic [rsg_pkg::NRB_W-1:0] cfg_wdata_i;
  logic                      res_valid_o;
  rsg_pkg::out_word_t        res_o;

  rotation_schedule_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // predictor state
  logic [rsg_pkg::NRB_W-1:0]  sched_nrb;
  logic [rsg_pkg::MASK_W-1:0] ligand_masks[N_ATOMS];
  int unsigned                ligand_len;
  rsg_pkg::out_word_t         sched_queue[$];
  int unsigned                errors;
  int unsigned                stall_cycles;
  int unsigned                idle_pct;

  // schedule produced by one ligand load
  task automatic predict_schedule();
    int unsigned nb;
    int unsigned cnt[N_ATOMS];
    int unsigned ids[N_ATOMS];
    bit          fresh[N_ATOMS];
    logic [rsg_pkg::MASK_W-1:0] lim;
    int unsigned total, k, c, id, j, r, bond;
    rsg_pkg::out_word_t w;
    nb = (sched_nrb > 16) ? 16 : sched_nrb;
    lim = rsg_pkg::MASK_W'((17'h1 << nb) - 1);
    total = 0;
    for (int i = 0; i < ligand_len; i++) begin
      ids[i] = i;
      fresh[i] = 1'b1;
      cnt[i] = 1 + $countones(ligand_masks[i] & lim);
      total += cnt[i];
    end
    // stable descending insertion sort
    for (int i = 1; i < ligand_len; i++) begin
      c = cnt[i]; id = ids[i]; j = i;
      while (j > 0 && cnt[j-1] < c) begin
        cnt[j] = cnt[j-1]; ids[j] = ids[j-1]; j--;
      end
      cnt[j] = c; ids[j] = id;
    end
    k = 0;
    while (ligand_len > 0 && cnt[0] != 0 && k < N_ROT) begin
      id = ids[0];
      c = cnt[0];
      bond = 0;
      if (c != 1) begin
        r = c - 1;
        for (int b = nb - 1; b >= 0; b--) begin
          if ((ligand_masks[id] & lim) >> b & 1) begin
            if (r == 1) begin
              bond = b;
              break;
            end
            r--;
          end
        end
      end
      w = '0;
      w.atom_id    = rsg_pkg::ATOM_W'(id);
      w.bond_index = rsg_pkg::BOND_W'(bond);
      w.is_general = (c == 1);
      w.is_first   = fresh[id];
      fresh[id] = 1'b0;
      sched_queue.push_back(w);
      // move head back past larger counts
      c = c - 1;
      j = 0;
      while (j + 1 < ligand_len && cnt[j+1] > c) begin
        cnt[j] = cnt[j+1]; ids[j] = ids[j+1]; j++;
      end
      cnt[j] = c; ids[j] = id;
      k++;
    end
    if (k > 0) begin
      sched_queue[$].total_required = rsg_pkg::TOT_W'(total);
      sched_queue[$].overflow       = (cnt[0] != 0);
      sched_queue[$].last_entry     = 1'b1;
    end
    ligand_len = 0;
  endtask

  // model one accepted word
  task automatic accept_word(input rsg_pkg::in_word_t w);
    if (ligand_len < N_ATOMS) begin
      ligand_masks[ligand_len] = w.rotbond_mask;
      ligand_len++;
    end
    if (w.last_atom) predict_schedule();
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    rsg_pkg::out_word_t exp_w;
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_valid_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (res_valid_o) begin
        if (sched_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $realtime, res_o);
          errors++;
        end else begin
          exp_w = sched_queue.pop_front();
          if (res_o !== exp_w) begin
            $display("%0t: mismatch expected %h actual %h (atom %0d/%0d bond %0d/%0d)",
                     $realtime, exp_w, res_o, exp_w.atom_id, res_o.atom_id,
                     exp_w.bond_index, res_o.bond_index);
            errors++;
          end
        end
      end
      if (stall_cycles > WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // send one word, waiting out busy
  task automatic send_word(input rsg_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start_i = 1'b1;
    in_i    = w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    accept_word(w);
    @(negedge clk_i);
    start_i = 1'b0;
    in_i    = '0;
  endtask

  task automatic drain();
    while (sched_queue.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_nrb(input logic [rsg_pkg::NRB_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sched_nrb = v;
  endtask

  // directed table: config, mask, last flag, typed single-entry schedule when chk is set
  typedef struct {
    logic [rsg_pkg::NRB_W-1:0]  nrb;
    logic [rsg_pkg::MASK_W-1:0] mask;
    logic                       last;
    logic                       chk;
    rsg_pkg::out_word_t         exp_word;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{5'd0,  16'hFFFF, 1'b1, 1'b1, GEN_ONLY},
    '{5'd0,  16'h0000, 1'b1, 1'b1, GEN_ONLY},
    '{5'd0,  16'hFFFF, 1'b1, 1'b1, GEN_ONLY},
    '{5'd16, 16'hFFFF, 1'b1, 1'b0, '0},
    '{5'd16, 16'h0000, 1'b1, 1'b1, GEN_ONLY},
    '{5'd16, 16'h8001, 1'b0, 1'b0, '0},
    '{5'd16, 16'h00F0, 1'b0, 1'b0, '0},
    '{5'd16, 16'h0000, 1'b1, 1'b0, '0},
    '{5'd31, 16'hA5A5, 1'b1, 1'b0, '0},
    '{5'd17, 16'h5A5A, 1'b1, 1'b0, '0},
    '{5'd4,  16'hFFFF, 1'b0, 1'b0, '0},
    '{5'd4,  16'h000F, 1'b1, 1'b0, '0},
    '{5'd1,  16'h0001, 1'b1, 1'b0, '0}
  };

  initial begin
    rsg_pkg::in_word_t w;
    int unsigned n_atoms, sent;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    sched_nrb = '0;
    ligand_len = 0;
    errors = 0;
    stall_cycles = 0;
    idle_pct = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first row needs no config write: zero bonds is the reset value
    for (int i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].nrb != sched_nrb) write_nrb(dir_tab[i].nrb);
      if (dir_tab[i].chk) drain();
      w = '{rotbond_mask: dir_tab[i].mask, last_atom: dir_tab[i].last};
      send_word(w);
      if (dir_tab[i].chk) sched_queue[0] = dir_tab[i].exp_word;
    end
    // too many atoms, full masks: schedule overflows
    write_nrb(5'd16);
    for (int i = 0; i < 34; i++) begin
      w = '{rotbond_mask: 16'hFFFF, last_atom: (i == 33)};
      send_word(w);
    end

    // random ligands over idle phases and settings
    sent = 0;
    for (int ph = 0; sent < 300; ph++) begin
      unique case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 0;
        default: idle_pct = 33;
      endcase
      write_nrb((ph % 5 == 0) ? 5'd16 : (ph % 5 == 1) ? 5'd0 :
                rsg_pkg::NRB_W'($urandom_range(31)));
      for (int l = 0; l < 4; l++) begin
        n_atoms = ($urandom_range(9) == 0) ? $urandom_range(33, 20) : $urandom_range(6, 1);
        for (int a = 0; a < n_atoms; a++) begin
          w.rotbond_mask = $urandom_range(3) == 0 ? rsg_pkg::MASK_W'($urandom) :
                           rsg_pkg::MASK_W'(1 << $urandom_range(15)) |
                           rsg_pkg::MASK_W'(1 << $urandom_range(15));
          w.last_atom = (a == n_atoms - 1);
          send_word(w);
          sent++;
        end
        // after the third ligand of each phase, hold until the whole schedule has come out
        if (l == 2) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
